// ===== hdl/slsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package slsc_pkg;

    localparam int NUM_STAIRS = 16;
    localparam int FULL_LEVEL = 255;

    // field widths
    localparam int POS_W   = 16;
    localparam int MS_W    = 16;
    localparam int BRT_W   = 8;
    localparam int IDX_W   = 6;
    localparam int LVL_W   = 9;
    localparam int CODE_W  = 2;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    // divider: quotient never exceeds FULL_LEVEL
    localparam int QW     = 8;
    localparam int CNT_W  = $clog2(QW);
    localparam int REM_W  = MS_W + QW;
    localparam int CONS_W = MS_W + IDX_W;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_ANIM_DUR = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_STEP_DUR = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_OFF_BRT  = 2'd2;

    localparam logic [CODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [CODE_W-1:0] MODE_UP   = 2'd1;
    localparam logic [CODE_W-1:0] MODE_HOLD = 2'd2;
    localparam logic [CODE_W-1:0] MODE_DOWN = 2'd3;

    localparam logic [CODE_W-1:0] ZONE_BOT  = 2'd0;
    localparam logic [CODE_W-1:0] ZONE_MID  = 2'd1;
    localparam logic [CODE_W-1:0] ZONE_TOP  = 2'd2;
    localparam logic [CODE_W-1:0] ZONE_NONE = 2'd3;

    localparam logic [CODE_W-1:0] DIR_UP   = 2'd0;
    localparam logic [CODE_W-1:0] DIR_DOWN = 2'd1;
    localparam logic [CODE_W-1:0] DIR_NONE = 2'd2;

    // xlo, xhi, ylo, yhi per box, all bounds open, bottom box first
    localparam int ZONE_BOX [3][4] = '{
        '{-100,  50,  10, 170},
        '{ -60,  60, 130, 530},
        '{-110,  10, 490, 580}
    };

    typedef struct packed {
        logic load;
        logic eval;
        logic div_init;
        logic div_step;
        logic fin;
        logic next;
    } t_dp_cmd;

    typedef struct packed {
        logic partial;
        logic last;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== hdl/slsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slsc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_valid,
    output logic                o_s_ready,
    output logic                o_m_valid,
    input  wire                 i_m_ready,
    input  slsc_pkg::t_dp_stat  i_stat,
    output slsc_pkg::t_dp_cmd   o_cmd
);
    import slsc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.partial ? S_DINIT : S_OUT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = CNT_W'(QW - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_m_ready) begin
                    o_cmd.next = 1'b1;
                    n_state    = i_stat.last ? S_IDLE : S_EVAL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_OUT);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_ready && o_m_valid))
        else $error("input taken while a stair word is pending");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> (r_state == S_EVAL))
        else $error("accepted word did not start evaluation");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_cnt != '0)) |=>
        ((r_state == S_DIV) && (r_cnt == $past(r_cnt) - 1'b1)))
        else $error("divider count broken");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.next && i_stat.last) |=> (r_state == S_IDLE))
        else $error("no return to idle after final stair");

endmodule
`default_nettype wire

// ===== hdl/slsc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slsc_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [slsc_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  wire  [slsc_pkg::CFG_D_W-1:0]     i_cfg_wdata,
    input  wire  signed [slsc_pkg::POS_W-1:0] i_x_pos,
    input  wire  signed [slsc_pkg::POS_W-1:0] i_y_pos,
    input  wire  [slsc_pkg::MS_W-1:0]        i_elapsed_ms,
    input  slsc_pkg::t_dp_cmd                i_cmd,
    output slsc_pkg::t_dp_stat               o_stat,
    output logic [slsc_pkg::IDX_W-1:0]       o_stair_index,
    output logic [slsc_pkg::LVL_W-1:0]       o_level,
    output logic                             o_last_stair,
    output logic [slsc_pkg::CODE_W-1:0]      o_mode_now,
    output logic [slsc_pkg::CODE_W-1:0]      o_presence_zone,
    output logic [slsc_pkg::CODE_W-1:0]      o_sweep_direction
);
    import slsc_pkg::*;

    // configuration
    logic [MS_W-1:0]   r_anim_dur;
    logic [MS_W-1:0]   r_step_dur;
    logic [BRT_W-1:0]  r_off_brt;

    // controller state kept across words
    logic [CODE_W-1:0] r_mode, n_mode;
    logic [CODE_W-1:0] r_dir, n_dir;
    logic [MS_W-1:0]   r_anim, n_anim;

    // per-word working registers
    logic [CODE_W-1:0] r_zone, zone;
    logic [CODE_W-1:0] r_lvl_mode;
    logic              r_walk_up;
    logic [CONS_W-1:0] r_cons;
    logic [IDX_W-1:0]  r_idx;
    logic [MS_W-1:0]   r_ts;
    logic [LVL_W-1:0]  r_level;

    // divider
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_dsr;
    logic [QW-1:0]     r_quo;

    logic [MS_W-1:0]   step_eff;
    logic [MS_W:0]     t_sum;
    logic [MS_W-1:0]   t_clamp;
    logic              ts_zero, ts_full, sweep;
    logic [CONS_W-1:0] diff;
    logic [MS_W-1:0]   d16;
    logic [QW-1:0]     frac;
    logic              is_end;
    logic [LVL_W-1:0]  lvl_calc;
    logic [LVL_W-1:0]  sweep_lvl;

    assign step_eff = (r_step_dur == '0) ? MS_W'(1) : r_step_dur;

    // first matching box wins, so scan from the last one down
    always_comb begin
        zone = ZONE_NONE;
        for (int z = 2; z >= 0; z--) begin
            if (ZONE_BOX[z][0] < int'(i_x_pos) && int'(i_x_pos) < ZONE_BOX[z][1] &&
                ZONE_BOX[z][2] < int'(i_y_pos) && int'(i_y_pos) < ZONE_BOX[z][3]) begin
                zone = CODE_W'(z);
            end
        end
    end

    assign t_sum   = {1'b0, r_anim} + {1'b0, i_elapsed_ms};
    assign t_clamp = (t_sum > {1'b0, r_anim_dur}) ? r_anim_dur : t_sum[MS_W-1:0];

    always_comb begin
        n_mode = r_mode;
        n_dir  = r_dir;
        n_anim = r_anim;
        case (r_mode)
            MODE_OFF: begin
                n_anim = '0;
                if (zone == ZONE_MID) begin
                    n_mode = MODE_HOLD;
                end else if (zone == ZONE_BOT) begin
                    n_mode = MODE_UP;
                    n_dir  = DIR_UP;
                end else if (zone == ZONE_TOP) begin
                    n_mode = MODE_UP;
                    n_dir  = DIR_DOWN;
                end
            end
            MODE_HOLD: begin
                n_anim = r_anim_dur;
                if (zone == ZONE_NONE) begin
                    n_mode = MODE_DOWN;
                    n_anim = '0;
                end
            end
            default: begin
                n_anim = t_clamp;
                if (t_clamp >= r_anim_dur) begin
                    if (zone == ZONE_NONE) begin
                        n_mode = MODE_OFF;
                        n_dir  = DIR_NONE;
                    end else begin
                        n_mode = MODE_HOLD;
                    end
                end
            end
        endcase
    end

    // time already taken by the stairs before this one in walk order
    assign sweep   = (r_lvl_mode == MODE_UP) || (r_lvl_mode == MODE_DOWN);
    assign ts_zero = (CONS_W'(r_anim) <= r_cons);
    assign diff    = CONS_W'(r_anim) - r_cons;
    assign d16     = diff[MS_W-1:0];
    assign ts_full = !ts_zero && (d16 >= step_eff);

    assign o_stat.partial = sweep && !ts_zero && !ts_full;
    assign o_stat.last    = (r_idx == IDX_W'(NUM_STAIRS - 1));

    assign is_end = (r_idx == '0) || (r_idx == IDX_W'(NUM_STAIRS - 1));
    assign frac   = i_cmd.fin ? r_quo : (ts_full ? QW'(FULL_LEVEL) : '0);

    always_comb begin
        if (r_lvl_mode == MODE_UP) begin
            sweep_lvl = {1'b0, frac};
        end else begin
            sweep_lvl = LVL_W'(FULL_LEVEL) - {1'b0, frac};
        end
        case (r_lvl_mode)
            MODE_OFF:  lvl_calc = is_end ? LVL_W'(r_off_brt) : '0;
            MODE_HOLD: lvl_calc = LVL_W'(FULL_LEVEL);
            default:   lvl_calc = sweep_lvl + LVL_W'(is_end);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anim_dur <= MS_W'(3000);
            r_step_dur <= MS_W'(187);
            r_off_brt  <= BRT_W'(10);
            r_mode     <= MODE_OFF;
            r_dir      <= DIR_NONE;
            r_anim     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_ANIM_DUR: r_anim_dur <= i_cfg_wdata[MS_W-1:0];
                    REG_STEP_DUR: r_step_dur <= i_cfg_wdata[MS_W-1:0];
                    REG_OFF_BRT:  r_off_brt  <= i_cfg_wdata[BRT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_mode <= n_mode;
                r_dir  <= n_dir;
                r_anim <= n_anim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zone     <= zone;
            r_lvl_mode <= r_mode;
            r_walk_up  <= (r_dir == DIR_UP);
            r_idx      <= '0;
            if (r_dir == DIR_UP) begin
                r_cons <= '0;
            end else begin
                r_cons <= CONS_W'(NUM_STAIRS - 1) * CONS_W'(step_eff);
            end
        end
        if (i_cmd.next) begin
            r_idx  <= r_idx + 1'b1;
            r_cons <= r_walk_up ? (r_cons + CONS_W'(step_eff))
                                : (r_cons - CONS_W'(step_eff));
        end
        if (i_cmd.eval) begin
            r_ts    <= d16;
            r_level <= lvl_calc;
        end
        if (i_cmd.fin) begin
            r_level <= lvl_calc;
        end
        if (i_cmd.div_init) begin
            r_rem <= REM_W'(r_ts) * REM_W'(FULL_LEVEL);
            r_dsr <= REM_W'(step_eff) << (QW - 1);
            r_quo <= '0;
        end
        // restoring division, one quotient bit a cycle
        if (i_cmd.div_step) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
        end
    end

    assign o_stair_index     = r_idx;
    assign o_level           = r_level;
    assign o_last_stair      = o_stat.last;
    assign o_mode_now        = r_mode;
    assign o_presence_zone   = r_zone;
    assign o_sweep_direction = r_dir;

endmodule
`default_nettype wire

// ===== hdl/stair_light_sweep_controller_core.sv =====
// Stair light sweep controller. Each input word carries a tracked position and the
// milliseconds since the previous word; the block picks the presence zone, steps its
// off / sweep up / hold / sweep down machine and then sends one output word per stair
// in ascending stair order, tlast on the final one. Levels show the mode as it was
// before the word; mode, zone and direction fields show the state after it. One word
// is handled at a time: each stair is evaluated and then presented, with a wait on
// m_axis_tready, and the one stair that is partly filled in a sweep also runs the
// serial divider (one quotient bit per cycle) between evaluation and presentation.
// Configuration writes take effect at once and must only be made while idle.
`timescale 1ns / 1ps
`default_nettype none
module stair_light_sweep_controller_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // x_pos[15:0], y_pos[31:16], elapsed_ms[47:32]
    input  wire  [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // stair_index[5:0], level[14:6], mode_now[16:15], presence_zone[18:17],
    // sweep_direction[20:19], zero[23:21]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import slsc_pkg::*;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [IDX_W-1:0]   stair_index;
    logic [LVL_W-1:0]   level;
    logic [CODE_W-1:0]  mode_now;
    logic [CODE_W-1:0]  presence_zone;
    logic [CODE_W-1:0]  sweep_direction;

    slsc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    slsc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_x_pos           (s_axis_tdata[15:0]),
        .i_y_pos           (s_axis_tdata[31:16]),
        .i_elapsed_ms      (s_axis_tdata[47:32]),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_stair_index     (stair_index),
        .o_level           (level),
        .o_last_stair      (m_axis_tlast),
        .o_mode_now        (mode_now),
        .o_presence_zone   (presence_zone),
        .o_sweep_direction (sweep_direction)
    );

    assign m_axis_tdata = {3'b000, sweep_direction, presence_zone, mode_now, level,
                           stair_index};

endmodule
`default_nettype wire

// ===== test/stair_sweep_checker.sv =====
`timescale 1ns / 1ps
module stair_sweep_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_wdata,
    input  wire         i_s_axis_tvalid,
    input  wire         i_s_axis_tready,
    input  wire  [47:0] i_s_axis_tdata,
    input  wire         i_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire  [23:0] i_m_axis_tdata,
    input  wire         i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_words_due
);
    import slsc_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  stair;
        logic [LVL_W-1:0]  level;
        logic              last;
        logic [CODE_W-1:0] mode;
        logic [CODE_W-1:0] zone;
        logic [CODE_W-1:0] dir;
    } t_stair_word;

    localparam logic [CODE_W-1:0] BOX_ZONE [3] = '{ZONE_BOT, ZONE_MID, ZONE_TOP};

    t_stair_word stair_words_due [$];

    logic [CODE_W-1:0] cur_mode;
    logic [CODE_W-1:0] cur_dir;
    logic [MS_W-1:0]   anim_t;
    logic [MS_W-1:0]   anim_dur;
    logic [MS_W-1:0]   step_dur;
    logic [BRT_W-1:0]  off_brt;

    t_stair_word got;
    t_stair_word want;

    // first box that holds the point wins, bounds are open
    function automatic logic [CODE_W-1:0] zone_of(input int x, input int y);
        for (int z = 0; z < 3; z++) begin
            if (ZONE_BOX[z][0] < x && x < ZONE_BOX[z][1] &&
                ZONE_BOX[z][2] < y && y < ZONE_BOX[z][3]) begin
                return BOX_ZONE[z];
            end
        end
        return ZONE_NONE;
    endfunction

    // steps the mode machine for one position word and queues one word per stair
    task automatic sweep_frame(input logic [47:0] frame);
        logic [LVL_W-1:0]  lvl [NUM_STAIRS];
        logic [CODE_W-1:0] zone;
        int unsigned       step;
        int unsigned       t;
        int unsigned       remaining;
        int unsigned       ts;
        int unsigned       frac;
        int unsigned       b;
        int                i;
        t_stair_word       w;
        zone = zone_of(int'($signed(frame[15:0])), int'($signed(frame[31:16])));
        if (cur_mode == MODE_OFF) begin
            anim_t = '0;
            for (int k = 0; k < NUM_STAIRS; k++) lvl[k] = '0;
            lvl[0] = LVL_W'(off_brt);
            lvl[NUM_STAIRS-1] = LVL_W'(off_brt);
            if (zone == ZONE_MID) begin
                cur_mode = MODE_HOLD;
            end else if (zone == ZONE_BOT) begin
                cur_mode = MODE_UP;
                cur_dir = DIR_UP;
            end else if (zone == ZONE_TOP) begin
                cur_mode = MODE_UP;
                cur_dir = DIR_DOWN;
            end
        end else if (cur_mode == MODE_HOLD) begin
            anim_t = anim_dur;
            for (int k = 0; k < NUM_STAIRS; k++) lvl[k] = LVL_W'(FULL_LEVEL);
            if (zone == ZONE_NONE) begin
                cur_mode = MODE_DOWN;
                anim_t = '0;
            end
        end else begin
            step = (step_dur == 0) ? 1 : step_dur;
            t = anim_t + frame[47:32];
            if (t > anim_dur) t = anim_dur;
            anim_t = MS_W'(t);
            remaining = t;
            // no direction yet sweeps top to bottom
            for (int k = 0; k < NUM_STAIRS; k++) begin
                i = (cur_dir == DIR_UP) ? k : NUM_STAIRS - 1 - k;
                ts = (remaining < step) ? remaining : step;
                remaining -= ts;
                frac = ts * FULL_LEVEL / step;
                b = (cur_mode == MODE_UP) ? frac : FULL_LEVEL - frac;
                if (i == 0 || i == NUM_STAIRS - 1) b++;
                lvl[i] = LVL_W'(b);
            end
            if (anim_t >= anim_dur) begin
                if (zone == ZONE_NONE) begin
                    cur_mode = MODE_OFF;
                    cur_dir = DIR_NONE;
                end else begin
                    cur_mode = MODE_HOLD;
                end
            end
        end
        for (int k = 0; k < NUM_STAIRS; k++) begin
            w.stair = IDX_W'(k);
            w.level = lvl[k];
            w.last  = (k == NUM_STAIRS - 1);
            w.mode  = cur_mode;
            w.zone  = zone;
            w.dir   = cur_dir;
            stair_words_due.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode = MODE_OFF;
            cur_dir  = DIR_NONE;
            anim_t   = '0;
            anim_dur = 16'd3000;
            step_dur = 16'd187;
            off_brt  = 8'd10;
            stair_words_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_ANIM_DUR: anim_dur = i_cfg_wdata;
                    REG_STEP_DUR: step_dur = i_cfg_wdata;
                    REG_OFF_BRT:  off_brt  = i_cfg_wdata[BRT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) sweep_frame(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.stair = i_m_axis_tdata[5:0];
                got.level = i_m_axis_tdata[14:6];
                got.last  = i_m_axis_tlast;
                got.mode  = i_m_axis_tdata[16:15];
                got.zone  = i_m_axis_tdata[18:17];
                got.dir   = i_m_axis_tdata[20:19];
                if (stair_words_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: stray word, nothing pending: stair %0d level %0d",
                                 $time, got.stair, got.level);
                    end
                end else begin
                    want = stair_words_due.pop_front();
                    if (got.stair != want.stair || got.level != want.level ||
                        got.last != want.last || got.mode != want.mode ||
                        got.zone != want.zone || got.dir != want.dir) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $write("%0t: mismatch (expected/actual) stair %0d/%0d ",
                                   $time, want.stair, got.stair);
                            $display("level %0d/%0d last %0b/%0b mode %0d/%0d %s",
                                     want.level, got.level, want.last, got.last,
                                     want.mode, got.mode, "");
                            $display("    zone %0d/%0d dir %0d/%0d",
                                     want.zone, got.zone, want.dir, got.dir);
                        end
                    end
                end
            end
        end
        o_words_due = stair_words_due.size();
    end

endmodule

// ===== test/stair_light_sweep_controller_core_tb.sv =====
`timescale 1ns / 1ps
module stair_light_sweep_controller_core_tb;
    import slsc_pkg::*;

    // index past the last register, writes there must be dropped
    localparam logic [CFG_A_W-1:0] REG_SPARE = 2'd3;

    localparam int SINK_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_PAD    = 64;
    localparam int RANDOM_ITEMS = 67;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [23:0] m_axis_tdata;
    wire         m_axis_tlast;

    int   fail_count;
    int   words_due;
    logic steady_source = 1'b0;
    logic steady_sink   = 1'b0;
    logic sink_hold_req = 1'b0;
    int   anim_set      = 3000;

    stair_light_sweep_controller_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    stair_sweep_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_words_due     (words_due)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_frame(input int x, input int y, input int el);
        if (!steady_source) begin
            while ($urandom_range(99) < 33) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tdata  <= {el[15:0], y[15:0], x[15:0]};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and wait until every stair word has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        // let the checker queue the word taken at the last edge
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_A_W-1:0] addr, input int data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data[15:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(input int anim, input int step, input int brt);
        settle();
        cfg_write(REG_ANIM_DUR, anim);
        cfg_write(REG_STEP_DUR, step);
        cfg_write(REG_OFF_BRT, brt);
        cfg_write(REG_SPARE, $urandom);
        i_cfg_wr_en <= 1'b0;
        anim_set = anim & 16'hFFFF;
    endtask

    // mostly points inside a box, some on or beside its edges, the rest anywhere
    task automatic random_phase(input int n);
        int r;
        int z;
        int x;
        int y;
        int el;
        repeat (n) begin
            r = $urandom_range(99);
            z = r % 3;
            if (r < 60) begin
                x = $urandom_range(ZONE_BOX[z][1] - ZONE_BOX[z][0] - 2) + ZONE_BOX[z][0] + 1;
                y = $urandom_range(ZONE_BOX[z][3] - ZONE_BOX[z][2] - 2) + ZONE_BOX[z][2] + 1;
            end else if (r < 72) begin
                x = ZONE_BOX[z][$urandom_range(1)] + $urandom_range(2) - 1;
                y = ZONE_BOX[z][2 + $urandom_range(1)] + $urandom_range(2) - 1;
            end else begin
                x = $urandom;
                y = $urandom;
            end
            r = $urandom_range(99);
            if (r < 55) el = $urandom_range(anim_set / 3 + 1);
            else if (r < 70) el = 0;
            else if (r < 85) el = $urandom;
            else el = 16'hFFFF;
            send_frame(x, y, el);
        end
    endtask

    initial begin : sink
        int held;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 0; held < SINK_HOLD; held++) @(posedge i_clk);
            end else if (steady_sink) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 33);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // reset settings; hold entered without a direction, then swept down
        send_frame(0, 300, 0);
        send_frame(0, 300, 16'hFFFF);
        send_frame(16'h7FFF, 16'h8000, 0);
        send_frame(16'h8000, 16'h7FFF, 1000);
        send_frame(0, 0, 16'hFFFF);
        send_frame(-100, 100, 16'h5555);
        // bottom start, partial fill, overlap of bottom and middle
        send_frame(-99, 11, 16'hAAAA);
        send_frame(49, 169, 0);
        send_frame(0, 150, 1500);
        send_frame(0, 150, 1500);
        send_frame(-109, 579, 7);
        send_frame(60, 500, 3);
        send_frame(0, 510, 100);
        send_frame(0, 600, 16'hFFFF);
        // top start sweeps top to bottom
        send_frame(-109, 579, 12);
        send_frame(9, 491, 2000);
        send_frame(-50, 540, 2000);
        send_frame(-59, 529, 0);
        send_frame(-60, 529, 40);
        send_frame(10, 300, 1);
        send_frame(-99, 169, 16'hFFFF);
        send_frame(16'h7FFF, 16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h8000, 16'h7FFF);

        // long receiver hold-off while words keep being offered
        set_config(3000, 187, 10);
        sink_hold_req = 1'b1;
        random_phase(RANDOM_ITEMS);

        // zero durations
        set_config(0, 0, 16'hFFFF);
        random_phase(RANDOM_ITEMS);

        steady_source = 1'b1;
        steady_sink   = 1'b1;
        set_config(16'hFFFF, 16'hFFFF, 16'hFF00);
        random_phase(RANDOM_ITEMS);
        steady_source = 1'b0;
        steady_sink   = 1'b0;

        set_config(1, 1, $urandom);
        random_phase(RANDOM_ITEMS);

        set_config($urandom_range(5000, 200), $urandom_range(400, 1), $urandom);
        random_phase(RANDOM_ITEMS);

        settle();
        if (fail_count == 0 && words_due == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
